// ===== hdl/goertzel_tone_detector_core_defines.svh =====
// ============================================================================
// Goertzel tone detector assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef GOERTZEL_TONE_DETECTOR_CORE_DEFINES_SVH
`define GOERTZEL_TONE_DETECTOR_CORE_DEFINES_SVH

// Condition and consequence in the same cycle.
`define GTD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define GTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gtd_pkg.sv =====
// ============================================================================
// Goertzel tone detector package
// Shared types, register indexes and constants of the detector.
// ============================================================================
package gtd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BLEN_W     = 10;
    localparam int COEF_W     = 16;
    localparam int THR_W      = 15;
    localparam int ENERGY_W   = 31;
    localparam int NORM_EXP_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COS_COEFF        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_COEFF        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESHOLD = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [BLEN_W-1:0] BLOCK_LENGTH_RST = 10'd205;

    // Input scaling chosen from the block length.
    localparam logic [BLEN_W-1:0] BLEN_SHIFT6_MIN = 10'd64;
    localparam logic [BLEN_W-1:0] BLEN_SHIFT5_MIN = 10'd160;
    localparam logic [2:0]        SCALE_SHORT     = 3'd7;
    localparam logic [2:0]        SCALE_MID       = 3'd6;
    localparam logic [2:0]        SCALE_LONG      = 3'd5;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_TONE   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_HI,
        S_UPDATE,
        S_ACCUM,
        S_COS_LO,
        S_COS_HI,
        S_SIN_LO,
        S_SIN_HI,
        S_SQ_LL,
        S_SQ_LH,
        S_SQ_HH,
        S_SQ_ADD,
        S_NORM,
        S_THR_MUL,
        S_COMPARE,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic [BLEN_W-1:0] block_length;
        logic [COEF_W-1:0] cos_coeff;
        logic [COEF_W-1:0] sin_coeff;
        logic [THR_W-1:0]  detect_threshold;
    } cfg_t;

    typedef struct packed {
        logic                load;
        status_t             status;
        logic [ENERGY_W-1:0] freq_energy;
        logic [ENERGY_W-1:0] time_energy;
    } out_ctl_t;

endpackage

// ===== hdl/gtd_mul.sv =====
// ============================================================================
// Goertzel shared multiplier
// Signed 17x17 multiplier with a registered, 32-bit truncated product.
// ============================================================================
module gtd_mul
    import gtd_pkg::*;
(
    input  logic               clk,
    input  logic signed [16:0] a,
    input  logic signed [16:0] b,
    output logic [31:0]        prod
);

    logic signed [33:0] full;
    logic [31:0]        prod_reg;

    assign full = a * b;
    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= full[31:0];
    end

endmodule

// ===== hdl/gtd_norm.sv =====
// ============================================================================
// Goertzel normalizer
// Shifts a word left one bit per cycle until bit 30 is set, counting shifts.
// ============================================================================
module gtd_norm
    import gtd_pkg::*;
(
    input  logic                  clk,
    input  logic                  start,
    input  logic [31:0]           word_in,
    output logic [31:0]           word,
    output logic [NORM_EXP_W-1:0] expo,
    output logic                  done
);

    logic [31:0]           word_reg, word_next;
    logic [NORM_EXP_W-1:0] exp_reg, exp_next;

    // Zero and negative words are left as they are with exponent zero.
    assign done = (word_reg == 32'd0) || word_reg[31] || word_reg[30];
    assign word = word_reg;
    assign expo = exp_reg;

    always_comb
    begin
        word_next = word_reg;
        exp_next  = exp_reg;
        if (start)
        begin
            word_next = word_in;
            exp_next  = '0;
        end
        else if (!done)
        begin
            word_next = {word_reg[30:0], 1'b0};
            exp_next  = exp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        exp_reg  <= exp_next;
    end

endmodule

// ===== hdl/gtd_seq.sv =====
// ============================================================================
// Goertzel sequencer
// Runs the recursion, energy sum and block-end decision on one multiplier.
// ============================================================================
`include "goertzel_tone_detector_core_defines.svh"

module gtd_seq
    import gtd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                out_free,
    output out_ctl_t            out_ctl
);

    seq_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [31:0]         part_reg, part_next;
    logic [31:0]         d1_reg, d1_next;
    logic [31:0]         d2_reg, d2_next;
    logic [BLEN_W-1:0]   count_reg, count_next;
    logic [63:0]         acc_reg, acc_next;
    logic [31:0]         re_reg, re_next;
    logic [31:0]         im_reg, im_next;
    logic [31:0]         t_reg, t_next;
    logic [31:0]         fe_reg, fe_next;
    logic [31:0]         last_fe_reg, last_fe_next;
    logic [31:0]         last_te_reg, last_te_next;
    logic [31:0]         shifted_reg, shifted_next;
    status_t             pend_status_reg, pend_status_next;
    logic                pass_reg, pass_next;

    logic signed [16:0]    mul_a, mul_b;
    logic [31:0]           prod;
    logic                  norm_start;
    logic [31:0]           fe_w, te_w;
    logic [NORM_EXP_W-1:0] fe_exp, te_exp;
    logic                  fe_done, te_done;

    logic [2:0]  scale;
    logic [31:0] scaled;
    logic [63:0] sq_shifted;
    logic [31:0] prod_asr16;
    logic [31:0] mq;
    logic [31:0] sq_x;
    logic [31:0] t_lo, t_mid, sqh, fe_total;
    logic [31:0] nf, nf5, nf_shifted;
    logic [5:0]  diff, neg_diff;
    logic        tone;

    gtd_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    gtd_norm u_norm_fe (
        .clk     (clk),
        .start   (norm_start),
        .word_in (fe_total),
        .word    (fe_w),
        .expo    (fe_exp),
        .done    (fe_done)
    );

    gtd_norm u_norm_te (
        .clk     (clk),
        .start   (norm_start),
        .word_in (acc_reg[63:32]),
        .word    (te_w),
        .expo    (te_exp),
        .done    (te_done)
    );

    always_comb
    begin
        if (cfg.block_length >= BLEN_SHIFT5_MIN)
            scale = SCALE_LONG;
        else if (cfg.block_length >= BLEN_SHIFT6_MIN)
            scale = SCALE_MID;
        else
            scale = SCALE_SHORT;
    end

    assign scaled     = {{16{smp_reg[15]}}, smp_reg} << scale;
    assign sq_shifted = {32'd0, prod} << {scale, 1'b0};

    // The low partial product keeps only its upper half, sign extended.
    assign prod_asr16 = {{16{prod[31]}}, prod[31:16]};
    assign mq         = prod + part_reg;

    assign sq_x     = pass_reg ? im_reg : re_reg;
    assign t_lo     = {16'd0, prod[31:16]};
    assign t_mid    = {prod[30:0], 1'b0} + t_reg;
    assign sqh      = {{16{t_reg[31]}}, t_reg[31:16]} + prod;
    assign fe_total = pass_reg ? (fe_reg + sqh) : sqh;

    assign nf       = {{16{fe_w[31]}}, fe_w[31:16]};
    assign nf5      = {nf[29:0], 2'b00} + nf;
    assign diff     = {1'b0, te_exp} - {1'b0, fe_exp};
    assign neg_diff = 6'd0 - diff;
    assign nf_shifted = diff[5] ? 32'($signed(nf5) >>> neg_diff[4:0])
                                : (nf5 << diff[4:0]);

    assign tone = $signed(prod) < $signed(shifted_reg);

    assign s_tready = (state_reg == S_IDLE);

    // Multiplier operands for the step in progress.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_IDLE:
            begin
                mul_a = {cfg.cos_coeff[15], cfg.cos_coeff};
                mul_b = {1'b0, d1_reg[15:0]};
            end
            S_MUL_HI:
            begin
                mul_a = {cfg.cos_coeff[15], cfg.cos_coeff};
                mul_b = {d1_reg[31], d1_reg[31:16]};
            end
            S_UPDATE:
            begin
                mul_a = {smp_reg[15], smp_reg};
                mul_b = {smp_reg[15], smp_reg};
            end
            S_COS_LO:
            begin
                mul_a = {cfg.cos_coeff[15], cfg.cos_coeff};
                mul_b = {1'b0, d2_reg[15:0]};
            end
            S_COS_HI:
            begin
                mul_a = {cfg.cos_coeff[15], cfg.cos_coeff};
                mul_b = {d2_reg[31], d2_reg[31:16]};
            end
            S_SIN_LO:
            begin
                mul_a = {cfg.sin_coeff[15], cfg.sin_coeff};
                mul_b = {1'b0, d2_reg[15:0]};
            end
            S_SIN_HI:
            begin
                mul_a = {cfg.sin_coeff[15], cfg.sin_coeff};
                mul_b = {d2_reg[31], d2_reg[31:16]};
            end
            S_SQ_LL:
            begin
                mul_a = {1'b0, sq_x[15:0]};
                mul_b = {1'b0, sq_x[15:0]};
            end
            S_SQ_LH:
            begin
                mul_a = {1'b0, sq_x[15:0]};
                mul_b = {sq_x[31], sq_x[31:16]};
            end
            S_SQ_HH:
            begin
                mul_a = {sq_x[31], sq_x[31:16]};
                mul_b = {sq_x[31], sq_x[31:16]};
            end
            S_THR_MUL:
            begin
                mul_a = {2'b00, cfg.detect_threshold};
                mul_b = {te_w[31], te_w[31:16]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        smp_next         = smp_reg;
        part_next        = part_reg;
        d1_next          = d1_reg;
        d2_next          = d2_reg;
        count_next       = count_reg;
        acc_next         = acc_reg;
        re_next          = re_reg;
        im_next          = im_reg;
        t_next           = t_reg;
        fe_next          = fe_reg;
        last_fe_next     = last_fe_reg;
        last_te_next     = last_te_reg;
        shifted_next     = shifted_reg;
        pend_status_next = pend_status_reg;
        pass_next        = pass_reg;
        norm_start       = 1'b0;
        out_ctl.load        = 1'b0;
        out_ctl.status      = pend_status_reg;
        out_ctl.freq_energy = last_fe_reg[ENERGY_W-1:0];
        out_ctl.time_energy = last_te_reg[ENERGY_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    smp_next   = sample;
                    state_next = S_MUL_HI;
                end
            end
            S_MUL_HI:
            begin
                part_next  = prod_asr16;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                d1_next    = {mq[29:0], 2'b00} + scaled - d2_reg;
                d2_next    = d1_reg;
                count_next = count_reg + 1'b1;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                acc_next = acc_reg + sq_shifted;
                if (count_reg >= cfg.block_length)
                begin
                    state_next = S_COS_LO;
                end
                else if (out_free)
                begin
                    out_ctl.load   = 1'b1;
                    out_ctl.status = ST_NONE;
                    state_next     = S_IDLE;
                end
                else
                begin
                    pend_status_next = ST_NONE;
                    state_next       = S_OUT;
                end
            end
            S_COS_LO:
            begin
                pass_next  = 1'b0;
                state_next = S_COS_HI;
            end
            S_COS_HI:
            begin
                part_next  = prod_asr16;
                state_next = S_SIN_LO;
            end
            S_SIN_LO:
            begin
                re_next    = {mq[30:0], 1'b0} - d1_reg;
                state_next = S_SIN_HI;
            end
            S_SIN_HI:
            begin
                part_next  = prod_asr16;
                state_next = S_SQ_LL;
            end
            S_SQ_LL:
            begin
                // On the first pass the sine product finishes here.
                if (!pass_reg)
                    im_next = {mq[30:0], 1'b0};
                state_next = S_SQ_LH;
            end
            S_SQ_LH:
            begin
                t_next     = t_lo;
                state_next = S_SQ_HH;
            end
            S_SQ_HH:
            begin
                t_next     = t_mid;
                state_next = S_SQ_ADD;
            end
            S_SQ_ADD:
            begin
                fe_next = fe_total;
                if (!pass_reg)
                begin
                    pass_next  = 1'b1;
                    state_next = S_SQ_LL;
                end
                else
                begin
                    norm_start = 1'b1;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (fe_done && te_done)
                    state_next = S_THR_MUL;
            end
            S_THR_MUL:
            begin
                shifted_next = nf_shifted;
                state_next   = S_COMPARE;
            end
            S_COMPARE:
            begin
                pend_status_next = tone ? ST_TONE : ST_ABSENT;
                last_fe_next     = fe_reg;
                last_te_next     = acc_reg[63:32];
                acc_next         = '0;
                d1_next          = '0;
                d2_next          = '0;
                count_next       = '0;
                state_next       = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_ctl.load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            d1_reg          <= '0;
            d2_reg          <= '0;
            count_reg       <= '0;
            acc_reg         <= '0;
            last_fe_reg     <= '0;
            last_te_reg     <= '0;
            pend_status_reg <= ST_NONE;
            pass_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            d1_reg          <= d1_next;
            d2_reg          <= d2_next;
            count_reg       <= count_next;
            acc_reg         <= acc_next;
            last_fe_reg     <= last_fe_next;
            last_te_reg     <= last_te_next;
            pend_status_reg <= pend_status_next;
            pass_reg        <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg     <= smp_next;
        part_reg    <= part_next;
        re_reg      <= re_next;
        im_reg      <= im_next;
        t_reg       <= t_next;
        fe_reg      <= fe_next;
        shifted_reg <= shifted_next;
    end

    `GTD_ASSERT_NEXT(a_decision_made, (state_reg == S_COMPARE), (pend_status_reg == ST_ABSENT || pend_status_reg == ST_TONE), "block end without a decision")
    `GTD_ASSERT_NEXT(a_block_cleared, (state_reg == S_COMPARE), (acc_reg == 64'd0 && d1_reg == 32'd0 && d2_reg == 32'd0 && count_reg == '0), "block state not cleared")
    `GTD_ASSERT_SAME(a_load_when_free, out_ctl.load, out_free, "result word loaded over a pending word")

endmodule

// ===== hdl/goertzel_tone_detector_core.sv =====
// ============================================================================
// Goertzel tone detector core
// An ordinary sample goes through S_MUL_HI, S_UPDATE and S_ACCUM to its result
// word; a new sample is taken only back in S_IDLE, since all steps share one
// multiplier. A block-ending sample adds the block-end math states and the
// normalization, one shift per cycle, before its result word.
// Reset (rst_n, asynchronous) clears the block state and restores the registers.
// ============================================================================
module goertzel_tone_detector_core
    import gtd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] status, [32:2] freq_energy,
                                             // [63:33] time_energy
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    out_ctl_t out_ctl;
    logic     out_free;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    gtd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sample   (s_tdata),
        .out_free (out_free),
        .out_ctl  (out_ctl)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_LENGTH:     cfg_next.block_length     = cfg_data[BLEN_W-1:0];
                REG_COS_COEFF:        cfg_next.cos_coeff        = cfg_data[COEF_W-1:0];
                REG_SIN_COEFF:        cfg_next.sin_coeff        = cfg_data[COEF_W-1:0];
                REG_DETECT_THRESHOLD: cfg_next.detect_threshold = cfg_data[THR_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_ctl.load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {out_ctl.time_energy, out_ctl.freq_energy, out_ctl.status};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_length     <= BLOCK_LENGTH_RST;
            cfg_reg.cos_coeff        <= '0;
            cfg_reg.sin_coeff        <= '0;
            cfg_reg.detect_threshold <= '0;
            m_tvalid_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== dv/tb_goertzel_tone_detector_core.sv =====
// ============================================================================
// Goertzel tone detector core testbench
// Drives audio samples into the detector and checks every result word against
// a bit-accurate Goertzel predictor kept inside the bench. A short directed
// table comes first, then random phases with tone, noisy-tone and white-noise
// content under changing block lengths, coefficients and thresholds. Both
// stream sides idle at random, and the receiver holds off once for a long
// stretch so that the core backs up into its input.
// ============================================================================
module tb_goertzel_tone_detector_core;
    import gtd_pkg::*;

    localparam int RAND_ITEMS      = 530;
    localparam int MAX_GAP         = 18;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int QUIET_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 64;
    localparam int PRINT_CAP       = 40;

    typedef struct packed {
        status_t             status;
        logic [ENERGY_W-1:0] freq_energy;
        logic [ENERGY_W-1:0] time_energy;
    } tone_report_t;

    // One directed step: a register write, or a sample with an optional
    // hand-written status (energies are then zero).
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        status_t               status;
    } drill_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;    // [15:0] sample
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // [1:0] status, [32:2] freq_energy,
                                       // [63:33] time_energy
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor copy of the registers and of the block state.
    bit [BLEN_W-1:0] blk_len;
    bit [COEF_W-1:0] cos_q15;
    bit [COEF_W-1:0] sin_q15;
    bit [THR_W-1:0]  thr_mult;
    bit [BLEN_W-1:0] blk_count;
    bit [31:0]       delay1;
    bit [31:0]       delay2;
    bit [63:0]       time_energy_acc;
    bit [31:0]       held_freq_energy;
    bit [31:0]       held_time_energy;

    tone_report_t tone_reports_q[$];
    drill_row_t   drill_q[$];

    bit no_idle;
    int mismatches;
    int samples_sent;
    int reports_seen;
    int tone_hits;
    int tone_misses;
    int phases;
    int quiet_cycles;

    goertzel_tone_detector_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Q15 product of a coefficient and a 32-bit word, with the low partial
    // product cut down to its upper half before it is added.
    function automatic bit [31:0] q15_mul(bit [15:0] coef, bit [31:0] v);
        shortint c16;
        shortint h16;
        longint  c;
        longint  hi;
        longint  lo;
        longint  prod;
        bit [31:0] low_word;
        int      part;
        c16 = coef;
        h16 = v[31:16];
        c = c16;
        hi = h16;
        lo = v[15:0];
        prod = c * lo;
        low_word = prod[31:0];
        part = $signed(low_word) >>> 16;
        prod = c * hi + part;
        return prod[31:0];
    endfunction

    // Truncated upper word of the square of a signed 32-bit word.
    function automatic bit [31:0] square_upper(bit [31:0] x);
        shortint h16;
        longint  hi;
        longint  lo;
        longint  prod;
        bit [31:0] e1;
        bit [31:0] e2;
        bit [31:0] e3;
        int      t;
        h16 = x[31:16];
        hi = h16;
        lo = x[15:0];
        prod = lo * lo;
        e1 = prod[31:0];
        prod = lo * hi;
        e2 = {prod[30:0], 1'b0};
        prod = hi * hi;
        e3 = prod[31:0];
        e2 = e2 + (e1 >> 16);
        t = $signed(e2) >>> 16;
        return t + e3;
    endfunction

    function automatic int norm_shift(bit [31:0] e);
        int n;
        n = 0;
        if (e == 32'd0 || e[31])
        begin
            return 0;
        end
        while (!e[30])
        begin
            e = e << 1;
            n++;
        end
        return n;
    endfunction

    // Advances the block by one sample and returns the word it must produce.
    function automatic tone_report_t goertzel_step(bit [15:0] smp);
        int      shift_amt;
        shortint s16;
        int      scaled;
        longint  sq;
        bit [31:0] v0;
        bit [31:0] re;
        bit [31:0] im;
        bit [31:0] fe;
        bit [31:0] te;
        bit [31:0] nf;
        int      ef;
        int      et;
        int      diff;
        int      nf_s;
        int      nt_s;
        int      thr_i;
        int      lhs;
        int      rhs;
        shortint nt16;
        tone_report_t r;
        if (blk_len >= BLEN_SHIFT5_MIN)
        begin
            shift_amt = SCALE_LONG;
        end
        else if (blk_len >= BLEN_SHIFT6_MIN)
        begin
            shift_amt = SCALE_MID;
        end
        else
        begin
            shift_amt = SCALE_SHORT;
        end
        s16 = smp;
        scaled = s16 * (1 << shift_amt);
        v0 = (q15_mul(cos_q15, delay1) << 2) + scaled - delay2;
        sq = scaled;
        sq = sq * sq;
        time_energy_acc = time_energy_acc + sq;
        delay2 = delay1;
        delay1 = v0;
        blk_count = blk_count + 1'b1;
        r.status = ST_NONE;
        if (blk_count >= blk_len)
        begin
            re = (q15_mul(cos_q15, delay2) << 1) - v0;
            im = q15_mul(sin_q15, delay2) << 1;
            fe = square_upper(re) + square_upper(im);
            te = time_energy_acc[63:32];
            ef = norm_shift(fe);
            et = norm_shift(te);
            nf_s = $signed(fe << ef) >>> 16;
            nt_s = $signed(te << et) >>> 16;
            diff = et - ef;
            nf = nf_s * 5;
            nt16 = nt_s[15:0];
            thr_i = thr_mult;
            lhs = thr_i * nt16;
            if (diff < 0)
            begin
                rhs = $signed(nf) >>> (-diff);
            end
            else
            begin
                rhs = nf << diff;
            end
            r.status = (lhs < rhs) ? ST_TONE : ST_ABSENT;
            held_freq_energy = fe;
            held_time_energy = te;
            time_energy_acc = 64'd0;
            delay1 = 32'd0;
            delay2 = 32'd0;
            blk_count = '0;
        end
        r.freq_energy = held_freq_energy[ENERGY_W-1:0];
        r.time_energy = held_time_energy[ENERGY_W-1:0];
        return r;
    endfunction

    task automatic flag_report_error(string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic drill_add(logic is_cfg, logic [CFG_IDX_W-1:0] index,
                             logic [CFG_DATA_W-1:0] value, logic typed, status_t status);
        drill_row_t row;
        row.is_cfg = is_cfg;
        row.index = index;
        row.value = value;
        row.typed = typed;
        row.status = status;
        drill_q.push_back(row);
    endtask

    // Called at a falling edge; the caller lowers cfg_we before any sample.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            REG_BLOCK_LENGTH:     blk_len = value[BLEN_W-1:0];
            REG_COS_COEFF:        cos_q15 = value;
            REG_SIN_COEFF:        sin_q15 = value;
            REG_DETECT_THRESHOLD: thr_mult = value[THR_W-1:0];
            default:              ;
        endcase
        @(negedge clk);
    endtask

    // Stops offering and waits until every pending word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (tone_reports_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic typed, status_t typed_status);
        int gap;
        tone_report_t due;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        due = goertzel_step(smp);
        if (typed)
        begin
            due.status = typed_status;
            due.freq_energy = '0;
            due.time_energy = '0;
        end
        tone_reports_q.push_back(due);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic check_report();
        tone_report_t due;
        reports_seen++;
        if (m_tdata[1:0] == ST_TONE)
        begin
            tone_hits++;
        end
        else if (m_tdata[1:0] == ST_ABSENT)
        begin
            tone_misses++;
        end
        if (tone_reports_q.size() == 0)
        begin
            flag_report_error($sformatf("word %0d arrived with nothing pending: %h",
                                        reports_seen, m_tdata));
        end
        else
        begin
            due = tone_reports_q.pop_front();
            if (m_tdata[1:0] !== due.status || m_tdata[32:2] !== due.freq_energy
                || m_tdata[63:33] !== due.time_energy)
            begin
                flag_report_error($sformatf(
                    "word %0d got/due: status %0d/%0d freq %h/%h time %h/%h",
                    reports_seen, m_tdata[1:0], due.status, m_tdata[32:2],
                    due.freq_energy, m_tdata[63:33], due.time_energy));
            end
        end
    endtask

    // Result side: random ready gaps, plus one long hold-off.
    initial
    begin
        int gap;
        bit held_off;
        held_off = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (!held_off && reports_seen >= HOLD_OFF_AFTER)
            begin
                gap = HOLD_OFF_CYCLES;
                held_off = 1'b1;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
            check_report();
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("goertzel_tone_detector_core verification failed");
            $finish;
        end
    end

    initial
    begin
        drill_row_t row;
        int  k;
        int  len;
        int  pick;
        int  nb;
        int  xi;
        int  nz;
        int  noise_amp;
        int  rand_items;
        bit  tone_phase;
        real w;
        real sig_w;
        real ph;
        real amp;
        logic [CFG_DATA_W-1:0] cos_v;
        logic [CFG_DATA_W-1:0] sin_v;
        logic [CFG_DATA_W-1:0] thr_v;
        logic [SAMPLE_W-1:0]   smp;

        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 1'b0;
        mismatches = 0;
        samples_sent = 0;
        reports_seen = 0;
        tone_hits = 0;
        tone_misses = 0;
        phases = 0;
        quiet_cycles = 0;
        rand_items = 0;

        blk_len = BLOCK_LENGTH_RST;
        cos_q15 = '0;
        sin_q15 = '0;
        thr_mult = '0;
        blk_count = '0;
        delay1 = '0;
        delay2 = '0;
        time_energy_acc = '0;
        held_freq_energy = '0;
        held_time_energy = '0;

        // Straight after reset the block is far from its end, so nothing is
        // decided and both energies read zero.
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h7FFF, 1'b1, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h8000, 1'b1, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h0000, 1'b1, ST_NONE);
        // Dropping the length under the running count ends the block at once.
        drill_add(1'b1, REG_BLOCK_LENGTH, 16'd1, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h0000, 1'b0, ST_NONE);
        // A silent one-sample block with zero threshold: zero energies, absent.
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h0000, 1'b1, ST_ABSENT);
        drill_add(1'b1, REG_COS_COEFF, 16'h7FFF, 1'b0, ST_NONE);
        drill_add(1'b1, REG_SIN_COEFF, 16'h8000, 1'b0, ST_NONE);
        drill_add(1'b1, REG_DETECT_THRESHOLD, 16'h7FFF, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h7FFF, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h8000, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h0001, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'hFFFF, 1'b0, ST_NONE);
        drill_add(1'b1, REG_BLOCK_LENGTH, 16'd2, 1'b0, ST_NONE);
        drill_add(1'b1, REG_COS_COEFF, 16'h8000, 1'b0, ST_NONE);
        drill_add(1'b1, REG_SIN_COEFF, 16'h7FFF, 1'b0, ST_NONE);
        drill_add(1'b1, REG_DETECT_THRESHOLD, 16'h0000, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h7FFF, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h7FFF, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h8000, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h8000, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h5555, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'hAAAA, 1'b0, ST_NONE);
        drill_add(1'b1, REG_BLOCK_LENGTH, 16'd63, 1'b0, ST_NONE);
        drill_add(1'b1, REG_COS_COEFF, 16'h5A82, 1'b0, ST_NONE);
        drill_add(1'b1, REG_SIN_COEFF, 16'h5A82, 1'b0, ST_NONE);
        drill_add(1'b1, REG_DETECT_THRESHOLD, 16'd1, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h1234, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h0000, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'hFFFF, 1'b0, ST_NONE);
        drill_add(1'b0, REG_BLOCK_LENGTH, 16'h8000, 1'b0, ST_NONE);

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (k = 0; k < drill_q.size(); k++)
        begin
            row = drill_q[k];
            if (row.is_cfg)
            begin
                if (!drill_q[k-1].is_cfg)
                begin
                    wait_drained();
                end
                cfg_write(row.index, row.value);
            end
            else
            begin
                send_sample(row.value, row.typed, row.status);
            end
        end

        // Random phases. The block state is not cleared by a register write,
        // so a phase that keeps a long block and a later phase that shortens it
        // also exercise the early block end.
        while (rand_items < RAND_ITEMS)
        begin
            wait_drained();
            phases++;
            tone_phase = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 9) < 7)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    nb = $urandom_range(1, 40);
                end
                else if (pick < 62)
                begin
                    nb = $urandom_range(41, 63);
                end
                else if (pick < 72)
                begin
                    nb = $urandom_range(64, 191);
                end
                else if (pick < 88)
                begin
                    case ($urandom_range(0, 7))
                        0:       nb = 1;
                        1:       nb = 63;
                        2:       nb = 64;
                        3:       nb = 159;
                        4:       nb = 160;
                        5:       nb = 191;
                        6:       nb = 192;
                        default: nb = 1023;
                    endcase
                end
                else if (pick < 94)
                begin
                    nb = 1023;
                end
                else
                begin
                    nb = $urandom_range(192, 400);
                end
                cfg_write(REG_BLOCK_LENGTH, 16'(nb));
            end

            w = 3.14159265 * $urandom_range(1, 999) / 1000.0;
            if (tone_phase)
            begin
                cos_v = 16'($rtoi(32767.0 * $cos(w)));
                sin_v = 16'($rtoi(32767.0 * $sin(w)));
            end
            else
            begin
                pick = $urandom_range(0, 3);
                cos_v = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : 16'($urandom);
                pick = $urandom_range(0, 3);
                sin_v = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : 16'($urandom);
            end
            cfg_write(REG_COS_COEFF, cos_v);
            cfg_write(REG_SIN_COEFF, sin_v);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                thr_v = 16'd0;
            end
            else if (pick == 1)
            begin
                thr_v = 16'd32767;
            end
            else if (pick < 5)
            begin
                thr_v = 16'($urandom_range(0, 64));
            end
            else
            begin
                thr_v = 16'($urandom_range(0, 32767));
            end
            cfg_write(REG_DETECT_THRESHOLD, thr_v);

            // Mostly on-target tones; the rest sit off the coefficient.
            sig_w = ($urandom_range(0, 3) != 0) ? w
                    : 3.14159265 * $urandom_range(1, 999) / 1000.0;
            ph = 6.2831853 * $urandom_range(0, 999) / 1000.0;
            amp = ($urandom_range(0, 3) == 0) ? 32767.0 : $urandom_range(50, 32767);
            noise_amp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2000);
            if (blk_len <= 60)
            begin
                len = $urandom_range(blk_len, 3 * blk_len + 4);
            end
            else if (blk_len <= 200)
            begin
                len = blk_len + $urandom_range(0, 8);
            end
            else
            begin
                len = $urandom_range(10, 60);
            end
            no_idle = ($urandom_range(0, 4) == 0);

            for (k = 0; k < len && rand_items < RAND_ITEMS; k++)
            begin
                if (tone_phase)
                begin
                    xi = $rtoi(amp * $cos(sig_w * k + ph));
                    nz = $urandom_range(0, 2 * noise_amp);
                    xi = xi + nz - noise_amp;
                    if (xi > 32767)
                    begin
                        xi = 32767;
                    end
                    else if (xi < -32768)
                    begin
                        xi = -32768;
                    end
                    smp = xi[15:0];
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       smp = 16'h8000;
                        1:       smp = 16'h7FFF;
                        2:       smp = 16'h0000;
                        default: smp = 16'hFFFF;
                    endcase
                end
                else
                begin
                    smp = 16'($urandom);
                end
                send_sample(smp, 1'b0, ST_NONE);
                rand_items++;
            end
        end

        wait_drained();
        no_idle = 1'b0;
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Run covered %0d samples in %0d random phases after the directed table.",
                 samples_sent, phases);
        $display("Checked %0d result words: %0d tone decisions, %0d absent, %0d mismatches.",
                 reports_seen, tone_hits, tone_misses, mismatches);
        if (mismatches == 0)
        begin
            $display("goertzel_tone_detector_core verification clean");
        end
        else
        begin
            $display("goertzel_tone_detector_core verification failed");
        end
        $finish;
    end

endmodule
